@@ design/hda_pkg.sv @@
`timescale 1ns / 1ps
package hda_pkg;
    localparam int SUM_W = 48;
    localparam logic [1:0] MODE_L1   = 2'd0;
    localparam logic [1:0] MODE_L2   = 2'd1;
    localparam logic [1:0] MODE_CHI  = 2'd2;
    localparam logic [1:0] MODE_NONE = 2'd3;
    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;

    typedef struct packed {
        logic [15:0] bin_a;
        logic [15:0] bin_b;
        logic        last_bin;
    } hda_in_t;

    typedef struct packed {
        logic [31:0] distance;
        logic        saturated;
    } hda_out_t;

    // classified work for the back part
    typedef struct packed {
        logic [1:0]  mode;
        logic [32:0] num;    // 2*diff^2 for chi-squared, term otherwise
        logic [16:0] den;    // a+b for chi-squared
        logic        last;
    } hda_work_t;
endpackage

@@ design/hda_front.sv @@
`timescale 1ns / 1ps
module hda_front
    import hda_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_push,
    input  hda_in_t   in_data,
    input  logic [1:0] mode,
    output logic      in_full,
    output logic      wk_valid,
    output hda_work_t wk_data,
    input  logic      wk_pop
);
    hda_work_t q_reg [QDEPTH];
    logic [QPTR_W-1:0] wp_reg, rp_reg;
    logic [QPTR_W:0] cnt_reg;
    logic [15:0] diff;
    logic [31:0] sq;
    hda_work_t w;

    // classify the request into a term or a division job
    always_comb
    begin
        diff = (in_data.bin_a >= in_data.bin_b) ? in_data.bin_a - in_data.bin_b
                                                : in_data.bin_b - in_data.bin_a;
        sq = diff * diff;
        w.mode = mode;
        w.last = in_data.last_bin;
        w.den  = {1'b0, in_data.bin_a} + {1'b0, in_data.bin_b};
        case (mode)
            MODE_L1:  w.num = {17'd0, diff};
            MODE_L2:  w.num = {1'b0, sq};
            MODE_CHI: w.num = {sq, 1'b0};
            default:  w.num = '0;
        endcase
    end

    assign in_full  = (cnt_reg == (QPTR_W+1)'(QDEPTH));
    assign wk_valid = (cnt_reg != '0);
    assign wk_data  = q_reg[rp_reg];

    // hold queued jobs
    always_ff @(posedge clk)
    begin
        if (in_push && !in_full)
            q_reg[wp_reg] <= w;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (in_push && !in_full)
                wp_reg <= wp_reg + 1'b1;
            if (wk_pop && wk_valid)
                rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (QPTR_W+1)'(in_push && !in_full)
                               - (QPTR_W+1)'(wk_pop && wk_valid);
        end
    end
endmodule

@@ design/hda_back.sv @@
`timescale 1ns / 1ps
module hda_back
    import hda_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      wk_valid,
    input  hda_work_t wk_data,
    output logic      wk_pop,
    output logic      out_valid,
    output hda_out_t  out_data,
    input  logic      out_pop
);
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIV  = 3'd1;
    localparam logic [2:0] ST_SQRT = 3'd2;
    localparam logic [2:0] ST_FIN  = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [2:0] st_reg;
    hda_work_t job_reg;
    logic [SUM_W-1:0] sum_reg;
    logic clip_reg;
    logic [5:0] cnt_reg;
    logic [33:0] rem_reg;
    logic [32:0] quo_reg;
    logic [SUM_W-1:0] sv_reg, root_reg, bit_reg;
    logic ov_reg;
    hda_out_t res_reg;

    logic [SUM_W-1:0] term, room;
    logic [33:0] rsh;
    logic [SUM_W-1:0] rb;
    logic [SUM_W-1:0] dist48;

    assign wk_pop = (st_reg == ST_IDLE) && wk_valid;
    assign out_valid = ov_reg;
    assign out_data = res_reg;

    always_comb
    begin
        rsh  = {rem_reg[32:0], quo_reg[32]};
        rb   = root_reg + bit_reg;
        room = SUM_MAX - sum_reg;
        dist48 = (job_reg.mode == MODE_L2) ? root_reg :
                 (job_reg.mode == MODE_NONE) ? '0 : sum_reg;
        term = (job_reg.mode == MODE_CHI) ? {15'd0, quo_reg} : {15'd0, job_reg.num};
    end

    // run one job: optional restoring divide, add, optional root on last
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= ST_IDLE;
            sum_reg <= '0;
            clip_reg <= 1'b0;
            ov_reg <= 1'b0;
        end
        else
        begin
            if (out_pop && ov_reg && (st_reg != ST_OUT))
                ov_reg <= 1'b0;
            case (st_reg)
                ST_IDLE:
                begin
                    if (wk_pop)
                    begin
                        job_reg <= wk_data;
                        quo_reg <= (wk_data.mode == MODE_CHI && wk_data.den == '0) ?
                                   '0 : wk_data.num;
                        rem_reg <= '0;
                        cnt_reg <= 6'd33;
                        if (wk_data.mode == MODE_CHI && wk_data.den != '0)
                            st_reg <= ST_DIV;
                        else
                            st_reg <= ST_FIN;
                    end
                end
                ST_DIV:
                begin
                    // one quotient bit per cycle
                    if (rsh >= {17'd0, job_reg.den})
                    begin
                        rem_reg <= rsh - {17'd0, job_reg.den};
                        quo_reg <= {quo_reg[31:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= rsh;
                        quo_reg <= {quo_reg[31:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == 6'd1)
                        st_reg <= ST_FIN;
                end
                ST_FIN:
                begin
                    // add the term, saturating
                    if (term > room)
                    begin
                        sum_reg <= SUM_MAX;
                        clip_reg <= 1'b1;
                        sv_reg <= SUM_MAX;
                    end
                    else
                    begin
                        sum_reg <= sum_reg + term;
                        sv_reg <= sum_reg + term;
                    end
                    root_reg <= '0;
                    bit_reg <= {2'b01, {(SUM_W-2){1'b0}}};
                    if (!job_reg.last)
                        st_reg <= ST_IDLE;
                    else if (job_reg.mode == MODE_L2)
                        st_reg <= ST_SQRT;
                    else
                        st_reg <= ST_OUT;
                end
                ST_SQRT:
                begin
                    // one result bit per cycle
                    if (sv_reg >= rb)
                    begin
                        sv_reg <= sv_reg - rb;
                        root_reg <= (root_reg >> 1) + bit_reg;
                    end
                    else
                        root_reg <= root_reg >> 1;
                    bit_reg <= bit_reg >> 2;
                    if (bit_reg[0])
                        st_reg <= ST_OUT;
                end
                ST_OUT:
                begin
                    if (!ov_reg || out_pop)
                    begin
                        ov_reg <= 1'b1;
                        if (dist48[SUM_W-1:32] != '0)
                        begin
                            res_reg.distance <= '1;
                            res_reg.saturated <= 1'b1;
                        end
                        else
                        begin
                            res_reg.distance <= dist48[31:0];
                            res_reg.saturated <= clip_reg && (job_reg.mode != MODE_NONE);
                        end
                        sum_reg <= '0;
                        clip_reg <= 1'b0;
                        st_reg <= ST_IDLE;
                    end
                end
                default: st_reg <= ST_IDLE;
            endcase
        end
    end
endmodule

@@ design/histogram_distance_accumulator_top.sv @@
`timescale 1ns / 1ps
// Histogram distance accumulator. Push one bin pair per request; the front
// queues up to four requests while the back works. In the back, L1 and L2
// bins go straight to the saturating add; chi-squared bins with a nonzero sum
// first pass through a one-bit-per-cycle divider. The last bin of a histogram
// then loads the result, in L2 after a bit-serial square root. One result per
// histogram appears in the result register and holds until popped; the back
// keeps adding bins meanwhile and stalls only when the next last bin is ready.
module histogram_distance_accumulator_top
    import hda_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  hda_in_t  in_data,
    output logic     full,
    output logic     empty,
    input  logic     pop,
    output hda_out_t out_data,
    input  logic     cfg_valid,
    output logic     cfg_ready,
    input  logic [1:0] cfg_data
);
    logic [1:0] mode_reg;
    logic wk_valid, wk_pop, ov;
    hda_work_t wk_data;

    assign cfg_ready = 1'b1;
    assign empty = !ov;

    // hold the mode register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= MODE_L1;
        else if (cfg_valid)
            mode_reg <= cfg_data;
    end

    hda_front u_front (
        .clk(clk), .rst_n(rst_n), .in_push(push), .in_data(in_data),
        .mode(mode_reg), .in_full(full), .wk_valid(wk_valid),
        .wk_data(wk_data), .wk_pop(wk_pop)
    );

    hda_back u_back (
        .clk(clk), .rst_n(rst_n), .wk_valid(wk_valid), .wk_data(wk_data),
        .wk_pop(wk_pop), .out_valid(ov), .out_data(out_data), .out_pop(pop)
    );
endmodule

@@ design/hda_checker.sv @@
`timescale 1ns / 1ps
module hda_prop_checker
    import hda_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     full,
    input logic     empty,
    input logic     pop,
    input hda_out_t out_data
);
    // a waiting result holds until popped
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(out_data)))
        else $error("result changed while waiting");
    // a waiting result is fully defined
    a_known: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> !$isunknown(out_data))
        else $error("undefined result");
    // no result and room for requests right after reset
    a_rst: assert property (@(posedge clk) $rose(rst_n) |-> (empty && !full))
        else $error("result out of reset");
endmodule

bind histogram_distance_accumulator_top hda_prop_checker u_chk (
    .clk(clk), .rst_n(rst_n), .full(full), .empty(empty),
    .pop(pop), .out_data(out_data)
);

@@ tb/hda_checker.sv @@
`timescale 1ns / 1ps
module hda_checker
    import hda_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  logic       full,
    input  hda_in_t    in_data,
    input  logic       empty,
    input  logic       pop,
    input  hda_out_t   out_data,
    input  logic       cfg_valid,
    input  logic       cfg_ready,
    input  logic [1:0] cfg_data,
    output int         fail_count,
    output int         pending
);
    localparam logic [31:0] DIST_MAX = 32'hFFFF_FFFF;

    logic [1:0]       mode_q;
    logic [SUM_W-1:0] sum_q;
    logic             clipped_q;
    hda_out_t         dist_expected[$];

    // integer square root, floor
    function automatic logic [31:0] root_floor(input logic [SUM_W-1:0] v);
        logic [63:0] r;
        logic [63:0] t;
        r = '0;
        for (int k = 31; k >= 0; k--)
        begin
            t = r | (64'd1 << k);
            if (t * t <= {16'd0, v})
                r = t;
        end
        return r[31:0];
    endfunction

    // fold one bin pair into the sum; queue a result on the last bin
    task automatic bin_accumulate(input hda_in_t req);
        logic [16:0] diff;
        logic [16:0] den;
        logic [63:0] term;
        logic [63:0] dist_val;
        hda_out_t    res;
        diff = (req.bin_a >= req.bin_b) ? {1'b0, req.bin_a} - {1'b0, req.bin_b}
                                        : {1'b0, req.bin_b} - {1'b0, req.bin_a};
        den  = {1'b0, req.bin_a} + {1'b0, req.bin_b};
        term = '0;
        case (mode_q)
            MODE_L1:  term = {47'd0, diff};
            MODE_L2:  term = {47'd0, diff} * {47'd0, diff};
            MODE_CHI: if (den != '0) term = (64'd2 * diff * diff) / {47'd0, den};
            default:  term = '0;
        endcase
        if (term > {16'd0, SUM_MAX} - {16'd0, sum_q})
        begin
            sum_q     = SUM_MAX;
            clipped_q = 1'b1;
        end
        else
            sum_q = sum_q + term[SUM_W-1:0];
        if (!req.last_bin)
            return;
        res.saturated = clipped_q;
        case (mode_q)
            MODE_L2:   dist_val = {32'd0, root_floor(sum_q)};
            MODE_NONE: dist_val = '0;
            default:   dist_val = {16'd0, sum_q};
        endcase
        if (mode_q == MODE_NONE)
            res.saturated = 1'b0;
        if (dist_val > {32'd0, DIST_MAX})
        begin
            dist_val      = {32'd0, DIST_MAX};
            res.saturated = 1'b1;
        end
        res.distance = dist_val[31:0];
        dist_expected.push_back(res);
        sum_q     = '0;
        clipped_q = 1'b0;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_q     = MODE_L1;
            sum_q      = '0;
            clipped_q  = 1'b0;
            fail_count = 0;
            dist_expected.delete();
            pending    = 0;
        end
        else
        begin
            // compare the popped result with the oldest expectation
            if (pop && !empty)
            begin
                if (dist_expected.size() == 0)
                begin
                    $error("unexpected result distance=%0d", out_data.distance);
                    fail_count = fail_count + 1;
                end
                else
                begin
                    hda_out_t exp_res;
                    exp_res = dist_expected.pop_front();
                    if (exp_res.distance !== out_data.distance)
                    begin
                        $error("distance expected %0d actual %0d",
                               exp_res.distance, out_data.distance);
                        fail_count = fail_count + 1;
                    end
                    if (exp_res.saturated !== out_data.saturated)
                    begin
                        $error("saturated expected %0d actual %0d",
                               exp_res.saturated, out_data.saturated);
                        fail_count = fail_count + 1;
                    end
                end
            end
            if (push && !full)
                bin_accumulate(in_data);
            if (cfg_valid && cfg_ready)
                mode_q = cfg_data;
            pending = dist_expected.size();
        end
    end
endmodule

@@ tb/histogram_distance_accumulator_top_tb.sv @@
`timescale 1ns / 1ps
module histogram_distance_accumulator_top_tb;
    import hda_pkg::*;

    localparam int IDLE_LIMIT = 20000;

    logic       clk;
    logic       rst_n;
    logic       push;
    hda_in_t    in_data;
    logic       full;
    logic       empty;
    logic       pop;
    hda_out_t   out_data;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [1:0] cfg_data;
    int         fail_count;
    int         pending;
    int         idle_cycles;

    histogram_distance_accumulator_top u_top (
        .clk(clk), .rst_n(rst_n), .push(push), .in_data(in_data), .full(full),
        .empty(empty), .pop(pop), .out_data(out_data), .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    hda_checker u_checker (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .in_data(in_data),
        .empty(empty), .pop(pop), .out_data(out_data), .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready), .cfg_data(cfg_data), .fail_count(fail_count),
        .pending(pending)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    function automatic int gap_length();
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(10, 60);
        if ($urandom_range(0, 2) == 0)
            return $urandom_range(1, 3);
        return 0;
    endfunction

    // random result-side stalls, with quiet stretches
    initial
    begin
        int stall;
        pop = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if ($urandom_range(0, 299) < 100)
                pop <= 1'b1;
            else
            begin
                stall = gap_length();
                pop <= (stall == 0);
                repeat (stall) @(posedge clk);
                pop <= 1'b1;
            end
        end
    end

    // stall watchdog
    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT)
        begin
            $display("histogram_distance_accumulator_top_tb: errors");
            $finish;
        end
    end

    task automatic send_bin(input logic [15:0] a, input logic [15:0] b, input logic last);
        int gap;
        gap = gap_length();
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push    <= 1'b1;
        in_data <= '{bin_a: a, bin_b: b, last_bin: last};
        @(posedge clk);
        while (full)
            @(posedge clk);
    endtask

    task automatic drain_then_set(input logic [1:0] m);
        push <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= m;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [15:0] rand_bin();
        case ($urandom_range(0, 5))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'($urandom_range(0, 15));
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    initial
    begin
        int sent;
        int len;
        logic [1:0] m;
        rst_n     = 1'b0;
        push      = 1'b0;
        in_data   = '0;
        cfg_valid = 1'b0;
        cfg_data  = MODE_L1;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes in each mode, zero-sum chi bin, unused mode
        send_bin(16'hFFFF, 16'h0000, 1'b0);
        send_bin(16'h0000, 16'hFFFF, 1'b1);
        send_bin(16'h1234, 16'h1234, 1'b1);
        drain_then_set(MODE_L2);
        send_bin(16'hFFFF, 16'h0000, 1'b0);
        send_bin(16'h0003, 16'h0000, 1'b1);
        send_bin(16'h0000, 16'h0000, 1'b1);
        drain_then_set(MODE_CHI);
        send_bin(16'h0000, 16'h0000, 1'b0);
        send_bin(16'hFFFF, 16'h0000, 1'b0);
        send_bin(16'h0001, 16'hFFFE, 1'b1);
        drain_then_set(MODE_NONE);
        send_bin(16'hFFFF, 16'h0000, 1'b0);
        send_bin(16'h5555, 16'hAAAA, 1'b1);
        // L2 sum of maximal terms runs well past 32 bits before the root
        drain_then_set(MODE_L2);
        for (int i = 0; i < 65600; i += 4096)
            send_bin(16'hFFFF, 16'h0000, 1'b0);
        send_bin(16'hFFFF, 16'h0000, 1'b1);
        // L1 single maximal bin after clearing
        drain_then_set(MODE_L1);
        send_bin(16'hFFFF, 16'h0000, 1'b1);

        // random histograms, with a random mode set before some batches
        sent = 0;
        while (sent < 1100)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                m = 2'($urandom_range(0, 3));
                drain_then_set(m);
            end
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 8);
            for (int i = 0; i < len; i++)
            begin
                send_bin(rand_bin(), rand_bin(), (i == len - 1) || ($urandom_range(0, 49) == 0));
                sent++;
            end
        end
        push <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (fail_count == 0)
            $display("histogram_distance_accumulator_top_tb: clean");
        else
            $display("histogram_distance_accumulator_top_tb: errors");
        $finish;
    end
endmodule
